// ===== rtl/rplf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the row projection line finder.
// Holds the sizing constants and the input item type; no dependencies.
package rplf_pkg;

  localparam int unsigned MAX_ROW_WIDTH = 4096;
  localparam int unsigned MAX_ROWS      = 4096;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned SUM_W   = 20;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned QUANT_W = 4;
  localparam int unsigned SQ_W    = 2 * QUANT_W;

  // a row is dark when its sum stays below its width shifted left by DARK_SHIFT
  localparam int unsigned DARK_SHIFT = 6;

  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CNT_W:0]   WIDTH_LIM = (CNT_W + 1)'(MAX_ROW_WIDTH);
  localparam logic [CNT_W:0]   ROWS_LIM  = (CNT_W + 1)'(MAX_ROWS);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             frame_start;
    logic [ROW_W-1:0] frame_top;
  } pix_item_t;

  typedef struct packed {
    logic             hit;
    logic [ROW_W-1:0] line_row;
  } line_hit_t;

endpackage

// ===== rtl/row_projection_line_finder.sv =====
`timescale 1ns / 1ps
// Top level of the row projection line finder: input register, datapath, output register.
// Depends on rplf_pkg and rplf_datapath.
//
//   channel | ports                                            | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid, in_ready, in_pixel, in_row_end,        | input
//           | in_frame_start, in_frame_top                     |
//   out     | out_valid, out_ready, out_line_row               | output
//
// One pixel per cycle sustained while the result register is not stalled; out_valid rises
// once a row-end hit has passed the input register and the result register around the datapath.
// Synchronous active-low reset clears all row history and empties both registers.
// A stalled result holds the datapath; the input register still takes one pixel.
module row_projection_line_finder
  import rplf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_pixel,
  input  logic             in_row_end,
  input  logic             in_frame_start,
  input  logic [ROW_W-1:0] in_frame_top,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ROW_W-1:0] out_line_row
);

  logic             in_vld_r;
  pix_item_t        item_r;
  logic             out_vld_r, out_vld_nxt;
  logic [ROW_W-1:0] line_row_r;
  logic             consume;
  line_hit_t        res;

  assign consume  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || consume;

  rplf_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (consume),
    .item   (item_r),
    .result (res)
  );

  always_comb begin
    out_vld_nxt = out_vld_r && !out_ready;
    if (consume) begin
      out_vld_nxt = res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.pixel       <= in_pixel;
      item_r.row_end     <= in_row_end;
      item_r.frame_start <= in_frame_start;
      item_r.frame_top   <= in_frame_top;
    end
    if (consume && res.hit) begin
      line_row_r <= res.line_row;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_line_row = line_row_r;

  // a held pixel is never dropped while the result side stalls
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !consume |=> in_vld_r)
    else $error("pending pixel lost");

  // a detection always lands in the result register
  a_hit_out: assert property (@(posedge clk) disable iff (!rst_n)
    consume && res.hit |=> out_vld_r && (line_row_r == $past(res.line_row)))
    else $error("detected line not presented");

  // only a row end can produce a line
  a_hit_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    res.hit |-> item_r.row_end)
    else $error("line reported without row end");

  // an empty input register always accepts
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_ready)
    else $error("input blocked while empty");

endmodule

// ===== rtl/rplf_datapath.sv =====
`timescale 1ns / 1ps
// Row sum accumulation, row history and minimum test for one pixel per cycle while en is high.
// Depends on rplf_pkg.
module rplf_datapath
  import rplf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  pix_item_t item,
  output line_hit_t result
);

  logic [SUM_W-1:0] row_sum_r, row_sum_nxt;
  logic [CNT_W-1:0] pixel_count_r, pixel_count_nxt;
  logic [SUM_W-1:0] middle_sum_r, middle_sum_nxt;
  logic [CNT_W-1:0] middle_width_r, middle_width_nxt;
  logic [SUM_W-1:0] older_sum_r, older_sum_nxt;
  logic [CNT_W-1:0] rows_done_r, rows_done_nxt;
  logic [ROW_W-1:0] top_row_r, top_row_nxt;

  logic [SUM_W-1:0] row_sum_e, middle_sum_e, older_sum_e;
  logic [CNT_W-1:0] pixel_count_e, middle_width_e, rows_done_e;
  logic [ROW_W-1:0] top_row_e;

  logic [QUANT_W-1:0] q;
  logic [SQ_W-1:0]    sq;
  logic [SUM_W:0]     sum_ext;
  logic [SUM_W-1:0]   sum_acc;
  logic [CNT_W-1:0]   cnt_acc;
  logic               rows_open;
  logic               take_pix;
  logic [SUM_W-1:0]   dark_lim;
  logic               is_line;

  always_comb begin
    // frame start clears history before the pixel is taken
    row_sum_e      = item.frame_start ? '0 : row_sum_r;
    pixel_count_e  = item.frame_start ? '0 : pixel_count_r;
    middle_sum_e   = item.frame_start ? '0 : middle_sum_r;
    middle_width_e = item.frame_start ? '0 : middle_width_r;
    older_sum_e    = item.frame_start ? '0 : older_sum_r;
    rows_done_e    = item.frame_start ? '0 : rows_done_r;
    top_row_e      = item.frame_start ? item.frame_top : top_row_r;

    rows_open = {1'b0, rows_done_e} < ROWS_LIM;
    take_pix  = rows_open && ({1'b0, pixel_count_e} < WIDTH_LIM);

    q       = item.pixel[PIX_W-1 -: QUANT_W];
    sq      = SQ_W'(q * q);
    sum_ext = {1'b0, row_sum_e} + (SUM_W + 1)'(sq);
    sum_acc = row_sum_e;
    cnt_acc = pixel_count_e;
    if (take_pix) begin
      sum_acc = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
      cnt_acc = pixel_count_e + CNT_W'(1);
    end

    dark_lim = SUM_W'({middle_width_e, {DARK_SHIFT{1'b0}}});
    is_line  = item.row_end && rows_open && (rows_done_e >= CNT_W'(2)) &&
               (middle_width_e != '0) && (middle_sum_e < older_sum_e) &&
               (middle_sum_e < sum_acc) && (middle_sum_e < dark_lim);

    result.hit      = is_line;
    result.line_row = top_row_e + rows_done_e[ROW_W-1:0] - ROW_W'(1);

    row_sum_nxt      = sum_acc;
    pixel_count_nxt  = cnt_acc;
    middle_sum_nxt   = middle_sum_e;
    middle_width_nxt = middle_width_e;
    older_sum_nxt    = older_sum_e;
    rows_done_nxt    = rows_done_e;
    top_row_nxt      = top_row_e;
    if (item.row_end) begin
      if (rows_open) begin
        // shift the row history
        older_sum_nxt    = middle_sum_e;
        middle_sum_nxt   = sum_acc;
        middle_width_nxt = cnt_acc;
        rows_done_nxt    = rows_done_e + CNT_W'(1);
      end
      row_sum_nxt     = '0;
      pixel_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_sum_r      <= '0;
      pixel_count_r  <= '0;
      middle_sum_r   <= '0;
      middle_width_r <= '0;
      older_sum_r    <= '0;
      rows_done_r    <= '0;
      top_row_r      <= '0;
    end else if (en) begin
      row_sum_r      <= row_sum_nxt;
      pixel_count_r  <= pixel_count_nxt;
      middle_sum_r   <= middle_sum_nxt;
      middle_width_r <= middle_width_nxt;
      older_sum_r    <= older_sum_nxt;
      rows_done_r    <= rows_done_nxt;
      top_row_r      <= top_row_nxt;
    end
  end

endmodule
